// File: rtl/mtpe_pkg.sv
package mtpe_pkg;

  // Generator and reduction constants.
  localparam logic [31:0] LCG_MUL  = 32'd8253729;
  localparam logic [31:0] LCG_ADD  = 32'd2396403;
  localparam logic [31:0] WORD_MOD = 32'd2147483647;

  // Register reset values.
  localparam logic [31:0] BASE_RST  = 32'd0;
  localparam logic [28:0] COUNT_RST = 29'd2097152;
  localparam logic [31:0] SEED_RST  = 32'd5323;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_SEED  = 2'd2;

  localparam logic ACT_BEGIN = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_VERIFY,
    PH_DONE
  } phase_e;

  // What kind of beat sits in the evaluation stage.
  typedef enum logic [2:0] {
    K_BEGIN,
    K_IDLE,
    K_WRITE,
    K_VERIFY,
    K_DONE
  } kind_e;

  typedef struct packed {
    logic        action;
    logic [31:0] read_data;
  } in_t;

  typedef struct packed {
    logic [31:0] address;
    logic [28:0] word_index;
    logic [30:0] pattern_word;
    logic        is_write;
    logic        mismatch;
    logic        done_res;
    logic        passed;
  } out_t;

  // Work handed from the sequencer to the evaluation stage.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [28:0] word_index;
    logic [31:0] seed;
    logic [31:0] read_data;
    logic        last;
  } pipe_t;

endpackage

// File: rtl/memory_test_pattern_engine.sv
// Memory self-test engine: writes a pseudo-random word sequence, then reads
// it back and checks it.
// Input channel (in_valid_i / in_stall_o / in_data_i): each beat is either a
// begin command, which loads the start seed and enters the write phase, or a
// memory beat. A write beat yields the address and the pattern word to
// store; a verify beat carries the word read back from that address and
// yields whether it matched. Every input beat gives exactly one result beat
// on the output channel (out_valid_o / out_stall_i / out_data_o).
// Configuration is written through cfg_valid_i / cfg_idx_i / cfg_data_i,
// always ready; writes take effect on the next beat.
// A beat is held in the pipeline register, then its result in the output
// register. The first stage steps the generator (one 32 by 23 bit
// constant multiply), the second reduces the word modulo 2^31-1 and
// compares it with the read data.
// Throughput is one beat per cycle while the output is not stalled. When the
// output is stalled, the result and the item behind it stay held; two beats
// are buffered before the input is stalled.
// Reset puts the engine in its idle phase with no beats in flight and the
// registers at their reset values; beats before a begin command return
// all-zero results.
module memory_test_pattern_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mtpe_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mtpe_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i
);

  logic [31:0] base_q;
  logic [28:0] count_q;
  logic [31:0] seed_cfg_q;

  logic            p_valid_q;
  mtpe_pkg::pipe_t p_q;
  mtpe_pkg::pipe_t p_d;

  logic           out_valid_q;
  mtpe_pkg::out_t out_q;
  mtpe_pkg::out_t res;

  // Set once a verify beat has failed; later beats of the same test then
  // report a finished, failed test.
  logic failed_q, failed_d;

  logic out_take;
  logic p_take;
  logic in_accept;

  assign out_take  = ~out_valid_q | ~out_stall_i;
  assign p_take    = ~p_valid_q | out_take;
  assign in_accept = in_valid_i & p_take;

  assign in_stall_o  = ~p_take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Registers outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= mtpe_pkg::BASE_RST;
      count_q    <= mtpe_pkg::COUNT_RST;
      seed_cfg_q <= mtpe_pkg::SEED_RST;
    end else if (cfg_valid_i) begin
      if (cfg_idx_i == mtpe_pkg::CFG_BASE) begin
        base_q <= cfg_data_i;
      end
      if (cfg_idx_i == mtpe_pkg::CFG_COUNT) begin
        count_q <= cfg_data_i[28:0];
      end
      if (cfg_idx_i == mtpe_pkg::CFG_SEED) begin
        seed_cfg_q <= cfg_data_i;
      end
    end
  end

  mtpe_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .base_i   (base_q),
    .count_i  (count_q),
    .seed_i   (seed_cfg_q),
    .pipe_o   (p_d)
  );

  mtpe_eval u_eval (
    .pipe_i   (p_q),
    .failed_i (failed_q),
    .res_o    (res)
  );

  always_comb begin
    failed_d = failed_q;
    if (p_valid_q && out_take) begin
      if (p_q.kind == mtpe_pkg::K_BEGIN) begin
        failed_d = 1'b0;
      end else if (res.mismatch) begin
        failed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      failed_q    <= 1'b0;
    end else begin
      failed_q <= failed_d;
      if (p_take) begin
        p_valid_q <= in_valid_i;
      end
      if (out_take) begin
        out_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      p_q <= p_d;
    end
    if (out_take && p_valid_q) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_mis_ends_test : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.mismatch |-> out_q.done_res && !out_q.passed)
    else $error("mismatch result does not end the test as failed");

  a_write_not_failed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_write |-> !failed_q && !out_q.done_res)
    else $error("write beat seen inside a failed test");

  a_fail_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(p_valid_q && p_q.kind == mtpe_pkg::K_BEGIN) |=> failed_q)
    else $error("failure flag cleared without a begin command");

  a_mis_sets_fail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && out_take && res.mismatch |=> failed_q)
    else $error("mismatch did not mark the test as failed");
`endif

endmodule

// File: rtl/mtpe_ctrl.sv
module mtpe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  mtpe_pkg::in_t      item_i,
  input  logic [31:0]        base_i,
  input  logic [28:0]        count_i,
  input  logic [31:0]        seed_i,
  output mtpe_pkg::pipe_t    pipe_o
);

  mtpe_pkg::phase_e phase_q, phase_d;
  logic [31:0]      seed_q, seed_d;
  logic [28:0]      idx_q, idx_d;

  logic [31:0] seed_adv;
  logic [28:0] count_eff;
  logic        last;

  // One generator step; only the low 32 bits of the product are kept.
  assign seed_adv  = seed_q * mtpe_pkg::LCG_MUL + mtpe_pkg::LCG_ADD;
  // A zero word count behaves as a single word.
  assign count_eff = (count_i == 29'd0) ? 29'd1 : count_i;
  assign last      = ({1'b0, idx_q} + 30'd1) >= {1'b0, count_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mtpe_pkg::PH_IDLE;
      seed_q  <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      seed_q  <= seed_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    phase_d            = phase_q;
    seed_d             = seed_q;
    idx_d              = idx_q;
    pipe_o.kind        = mtpe_pkg::K_IDLE;
    pipe_o.address     = base_i + {1'b0, idx_q, 2'b00};
    pipe_o.word_index  = idx_q;
    pipe_o.seed        = seed_adv;
    pipe_o.read_data   = item_i.read_data;
    pipe_o.last        = last;

    if (item_i.action == mtpe_pkg::ACT_BEGIN) begin
      pipe_o.kind = mtpe_pkg::K_BEGIN;
      if (accept_i) begin
        phase_d = mtpe_pkg::PH_WRITE;
        seed_d  = seed_i;
        idx_d   = '0;
      end
    end else begin
      unique case (phase_q)
        mtpe_pkg::PH_IDLE: begin
          pipe_o.kind = mtpe_pkg::K_IDLE;
        end
        mtpe_pkg::PH_WRITE: begin
          pipe_o.kind = mtpe_pkg::K_WRITE;
          if (accept_i) begin
            if (last) begin
              phase_d = mtpe_pkg::PH_VERIFY;
              seed_d  = seed_i;
              idx_d   = '0;
            end else begin
              seed_d = seed_adv;
              idx_d  = idx_q + 29'd1;
            end
          end
        end
        mtpe_pkg::PH_VERIFY: begin
          // A mismatch is found one stage later; the evaluation stage
          // turns any beats that follow it into finished-test beats.
          pipe_o.kind = mtpe_pkg::K_VERIFY;
          if (accept_i) begin
            if (last) begin
              phase_d = mtpe_pkg::PH_DONE;
            end else begin
              seed_d = seed_adv;
              idx_d  = idx_q + 29'd1;
            end
          end
        end
        mtpe_pkg::PH_DONE: begin
          pipe_o.kind = mtpe_pkg::K_DONE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mtpe_eval.sv
module mtpe_eval (
  input  mtpe_pkg::pipe_t pipe_i,
  input  logic            failed_i,
  output mtpe_pkg::out_t  res_o
);

  logic [31:0] fold;
  logic [30:0] word;
  logic        differ;

  // Reduction modulo 2^31-1: fold the top bit back in, then one subtract.
  assign fold   = {1'b0, pipe_i.seed[30:0]} + {31'd0, pipe_i.seed[31]};
  assign word   = (fold >= mtpe_pkg::WORD_MOD) ? 31'(fold - mtpe_pkg::WORD_MOD)
                                               : fold[30:0];
  assign differ = pipe_i.read_data != {1'b0, word};

  always_comb begin
    res_o = '0;
    unique case (pipe_i.kind)
      mtpe_pkg::K_BEGIN, mtpe_pkg::K_IDLE: begin
        res_o = '0;
      end
      mtpe_pkg::K_WRITE: begin
        res_o.address      = pipe_i.address;
        res_o.word_index   = pipe_i.word_index;
        res_o.pattern_word = word;
        res_o.is_write     = 1'b1;
      end
      mtpe_pkg::K_VERIFY: begin
        if (failed_i) begin
          res_o.done_res = 1'b1;
        end else begin
          res_o.address      = pipe_i.address;
          res_o.word_index   = pipe_i.word_index;
          res_o.pattern_word = word;
          res_o.mismatch     = differ;
          res_o.done_res     = differ | pipe_i.last;
          res_o.passed       = ~differ & pipe_i.last;
        end
      end
      mtpe_pkg::K_DONE: begin
        res_o.done_res = 1'b1;
        res_o.passed   = ~failed_i;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// File: sim/memory_test_pattern_engine_tb.sv
module memory_test_pattern_engine_tb;

  // An action value of one is a memory beat; zero starts a new test.
  localparam logic       ACT_BEAT = 1'b1;
  // The index field is two bits wide, so one index names no register.
  localparam logic [1:0] CFG_NONE = 2'd3;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Long enough for a result still in the engine's pipeline, with margin.
  localparam int unsigned SETTLE_CYCLES  = 10;
  // Input beats per random phase at the least; the last test may run over.
  localparam int unsigned PHASE_BEATS    = 155;

  // Every input is given a known value from time zero on.
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  mtpe_pkg::in_t in_data_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0]  cfg_idx_i  = '0;
  logic [31:0] cfg_data_i = '0;

  logic in_stall_o;
  logic out_valid_o;
  mtpe_pkg::out_t out_data_o;
  logic cfg_ready_o;

  memory_test_pattern_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // The testbench's own copy of the register file, updated whenever a
  // register write is accepted.
  logic [31:0] base_addr_r  = mtpe_pkg::BASE_RST;
  logic [28:0] word_total_r = mtpe_pkg::COUNT_RST;
  logic [31:0] seed_init_r  = mtpe_pkg::SEED_RST;

  // The testbench's own copy of the engine state.
  mtpe_pkg::phase_e eng_phase = mtpe_pkg::PH_IDLE;
  logic [31:0] eng_seed   = '0;
  logic [28:0] eng_index  = '0;
  logic        eng_passed = 1'b0;

  // Results predicted for accepted beats, oldest first.
  mtpe_pkg::out_t pending_beats[$];

  int unsigned fault_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // One step of the linear congruential generator, modulo 2^32.
  function automatic logic [31:0] lcg_next(input logic [31:0] s);
    return s * mtpe_pkg::LCG_MUL + mtpe_pkg::LCG_ADD;
  endfunction

  // The stored pattern word is the seed reduced modulo 2^31-1.
  function automatic logic [30:0] word_of(input logic [31:0] s);
    logic [31:0] m;
    m = s % mtpe_pkg::WORD_MOD;
    return m[30:0];
  endfunction

  // The word a verify beat has to read back to pass at the current index.
  function automatic logic [31:0] next_read_back();
    return {1'b0, word_of(lcg_next(eng_seed))};
  endfunction

  // Predicts the result of one accepted beat and advances the state copy.
  function automatic mtpe_pkg::out_t step_pattern_engine(input mtpe_pkg::in_t beat);
    mtpe_pkg::out_t res;
    logic [31:0]    n_words;
    logic           at_last;
    logic [30:0]    gen_word;
    res = '0;
    // A word count of zero behaves as a single word.
    n_words = (word_total_r == '0) ? 32'd1 : {3'b000, word_total_r};
    at_last = ({3'b000, eng_index} + 32'd1) >= n_words;
    if (beat.action == mtpe_pkg::ACT_BEGIN) begin
      // A begin restarts the test from any phase and answers all zero.
      eng_seed   = seed_init_r;
      eng_index  = '0;
      eng_passed = 1'b0;
      eng_phase  = mtpe_pkg::PH_WRITE;
    end else if (eng_phase == mtpe_pkg::PH_WRITE || eng_phase == mtpe_pkg::PH_VERIFY) begin
      res.word_index   = eng_index;
      res.address      = base_addr_r + {1'b0, eng_index, 2'b00};
      eng_seed         = lcg_next(eng_seed);
      gen_word         = word_of(eng_seed);
      res.pattern_word = gen_word;
      if (eng_phase == mtpe_pkg::PH_WRITE) begin
        res.is_write = 1'b1;
        if (at_last) begin
          // The verify pass reloads the start seed as it stands now.
          eng_seed  = seed_init_r;
          eng_index = '0;
          eng_phase = mtpe_pkg::PH_VERIFY;
        end else begin
          eng_index = eng_index + 29'd1;
        end
      end else if (beat.read_data != {1'b0, gen_word}) begin
        res.mismatch = 1'b1;
        res.done_res = 1'b1;
        eng_passed   = 1'b0;
        eng_phase    = mtpe_pkg::PH_DONE;
      end else if (at_last) begin
        res.done_res = 1'b1;
        res.passed   = 1'b1;
        eng_passed   = 1'b1;
        eng_phase    = mtpe_pkg::PH_DONE;
      end else begin
        eng_index = eng_index + 29'd1;
      end
    end else if (eng_phase == mtpe_pkg::PH_DONE) begin
      // Beats after the end only report the outcome.
      res.done_res = 1'b1;
      res.passed   = eng_passed;
    end
    return res;
  endfunction

  // Presents one beat after a random idle stretch and waits until it is
  // taken. The payload is held unchanged while the engine stalls it.
  task automatic send_beat(input logic act, input logic [31:0] rd);
    mtpe_pkg::in_t beat;
    beat.action    = act;
    beat.read_data = rd;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_beats.push_back(step_pattern_engine(beat));
    items_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  // Each beat gives exactly one result, so the engine is then idle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mtpe_pkg::CFG_BASE:  base_addr_r  = value;
      mtpe_pkg::CFG_COUNT: word_total_r = value[28:0];
      mtpe_pkg::CFG_SEED:  seed_init_r  = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The receiver stalls at random; the chance is set per phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fault_count++;
    end
  endtask

  // Every result beat taken at a rising edge is checked against the
  // oldest prediction, field by field.
  always @(posedge clk_i) begin
    mtpe_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %p", $time, out_data_o);
        fault_count++;
      end else begin
        want = pending_beats.pop_front();
        report_field("address", want.address, out_data_o.address);
        report_field("word_index", 32'(want.word_index), 32'(out_data_o.word_index));
        report_field("pattern_word", 32'(want.pattern_word),
                     32'(out_data_o.pattern_word));
        report_field("is_write", 32'(want.is_write), 32'(out_data_o.is_write));
        report_field("mismatch", 32'(want.mismatch), 32'(out_data_o.mismatch));
        report_field("done_res", 32'(want.done_res), 32'(out_data_o.done_res));
        report_field("passed", 32'(want.passed), 32'(out_data_o.passed));
      end
    end
  end

  // The watchdog ends the run when no channel has moved a beat for too
  // long, which only happens if the engine hangs.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Right after reset the engine is idle, so a memory beat returns all
  // zeros. A test is then started with the reset register values; the
  // word count is large, so it stays in the write phase.
  task automatic test_idle_and_defaults();
    send_beat(ACT_BEAT, 32'hFFFF_FFFF);
    send_beat(mtpe_pkg::ACT_BEGIN, 32'h0000_0000);
    repeat (3) send_beat(ACT_BEAT, 32'h0000_0000);
    drain();
  endtask

  // Registers are rewritten while a test is in flight. The word count drops
  // below the current index, so the next write beat is the last one, and
  // the verify pass reloads the new seed. The data written to the count has
  // its upper bits set, which the engine must drop, and a write to the
  // unused index must change nothing. With the base near the top of the
  // address space the addresses wrap. A begin in the middle of a test
  // restarts it, and a bad read ends it as failed.
  task automatic test_wrap_and_live_regs();
    write_reg(mtpe_pkg::CFG_BASE, 32'hFFFF_FFF8);
    write_reg(mtpe_pkg::CFG_COUNT, 32'hE000_0002);
    write_reg(mtpe_pkg::CFG_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_NONE, 32'h1234_5678);
    send_beat(ACT_BEAT, 32'h0000_0000);
    send_beat(ACT_BEAT, next_read_back());
    send_beat(ACT_BEAT, next_read_back());
    send_beat(ACT_BEAT, 32'h0000_0000);
    send_beat(mtpe_pkg::ACT_BEGIN, 32'hFFFF_FFFF);
    send_beat(ACT_BEAT, 32'h0000_0000);
    send_beat(mtpe_pkg::ACT_BEGIN, 32'h0000_0000);
    send_beat(ACT_BEAT, 32'hFFFF_FFFF);
    send_beat(ACT_BEAT, 32'h0000_0000);
    send_beat(ACT_BEAT, next_read_back() ^ 32'h8000_0001);
    send_beat(ACT_BEAT, next_read_back());
    drain();
  endtask

  // A word count of zero runs as a single word. The zero seed gives the
  // generator's additive constant as its first state.
  task automatic test_single_word();
    write_reg(mtpe_pkg::CFG_BASE, 32'h0000_0000);
    write_reg(mtpe_pkg::CFG_COUNT, 32'h0000_0000);
    write_reg(mtpe_pkg::CFG_SEED, 32'h0000_0000);
    send_beat(mtpe_pkg::ACT_BEGIN, 32'h0000_0000);
    send_beat(ACT_BEAT, 32'h0000_0000);
    send_beat(ACT_BEAT, next_read_back());
    send_beat(ACT_BEAT, 32'hFFFF_FFFF);
    send_beat(mtpe_pkg::ACT_BEGIN, 32'h0000_0000);
    drain();
  endtask

  // Random load in phases with their own registers and idling. Most beats
  // form whole tests: a begin, the write pass, and a verify pass fed with
  // the right data and the odd corrupted word. Some tests are cut short and
  // a few beats are pure noise. Each phase ends with a test in flight, so
  // the register writes of the next phase land in the middle of one.
  task automatic test_random_load();
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n_words;
    int unsigned run_len;
    logic        noise_act;
    logic [31:0] rd;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 60;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 60;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct     = 10;
        end
      endcase
      case ($urandom_range(3))
        0:       write_reg(mtpe_pkg::CFG_BASE, 32'h0000_0000);
        1:       write_reg(mtpe_pkg::CFG_BASE, 32'hFFFF_FFFC);
        default: write_reg(mtpe_pkg::CFG_BASE, $urandom());
      endcase
      // Two phases use counts of 2^28 and 2^29-1; their tests never finish.
      if (ph == 5) begin
        write_reg(mtpe_pkg::CFG_COUNT, 32'h1000_0000);
      end else if (ph == 6) begin
        write_reg(mtpe_pkg::CFG_COUNT, 32'hFFFF_FFFF);
      end else begin
        write_reg(mtpe_pkg::CFG_COUNT, $urandom_range(0, 7));
      end
      if ($urandom_range(3) == 0) begin
        write_reg(mtpe_pkg::CFG_SEED, (ph % 2 == 1) ? 32'hFFFF_FFFF : 32'h0000_0000);
      end else begin
        write_reg(mtpe_pkg::CFG_SEED, $urandom());
      end
      n_words = (word_total_r == '0) ? 32'd1 : {3'b000, word_total_r};
      stop_at = items_sent + PHASE_BEATS;
      while (items_sent < stop_at) begin
        kind = $urandom_range(99);
        if (kind < 8) begin
          noise_act = 1'($urandom_range(1));
          send_beat(noise_act, $urandom());
        end else begin
          send_beat(mtpe_pkg::ACT_BEGIN, $urandom());
          run_len = 2 * n_words + 1 + $urandom_range(2);
          if (kind < 20) run_len = $urandom_range(0, run_len);
          if (run_len > 40) run_len = 40;
          for (int unsigned b = 0; b < run_len; b++) begin
            if (eng_phase != mtpe_pkg::PH_VERIFY) begin
              rd = $urandom();
            end else if ($urandom_range(99) < 4) begin
              rd = next_read_back() ^ (32'd1 << $urandom_range(31));
            end else begin
              rd = next_read_back();
            end
            send_beat(ACT_BEAT, rd);
          end
        end
      end
      send_beat(mtpe_pkg::ACT_BEGIN, $urandom());
      send_beat(ACT_BEAT, $urandom());
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_and_defaults();
    test_wrap_and_live_regs();
    test_single_word();
    test_random_load();
    // Give a stray late result the chance to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && pending_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
